// File: hw/rtl/cbpw_pkg.sv
// ----------------------------------------------------------------------------
// cbpw_pkg
// shared types and constants of the cubic bezier path walker
// ----------------------------------------------------------------------------
package cbpw_pkg;

    localparam int COORD_BITS       = 12;
    localparam int FRAC_BITS        = 10;
    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int TICK_DIVISOR_DEF = 5;

    localparam int TICK_W = 32;
    localparam int RATE_W = 11;
    localparam int WAIT_W = 16;
    localparam int POS_W  = 20;
    localparam int T_W    = 11;
    localparam int T2_W   = 12;
    localparam int T3_W   = 13;
    localparam int CW     = COORD_BITS + 6;
    localparam int BW     = T3_W + 1;
    localparam int PW     = CW + BW;
    localparam int AW     = 32;
    localparam int SEG_W  = 8 * COORD_BITS;

    localparam logic [T_W-1:0] T_MAX   = 11'd2047;
    localparam logic [T_W-1:0] T_LIMIT = 11'd950;

    localparam logic CFG_STEP_RATE = 1'b0;
    localparam logic CFG_END_WAIT  = 1'b1;

    // point slots inside one stored segment word
    localparam int PT_SX  = 0;
    localparam int PT_SY  = 1;
    localparam int PT_C0X = 2;
    localparam int PT_C0Y = 3;
    localparam int PT_C1X = 4;
    localparam int PT_C1Y = 5;
    localparam int PT_EX  = 6;
    localparam int PT_EY  = 7;

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_START   = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_ENDPT,
        ST_RESP
    } state_t;

    typedef enum logic [3:0] {
        MS_RATE,
        MS_TSQ,
        MS_TCUBE,
        MS_X1,
        MS_X2,
        MS_X3,
        MS_Y1,
        MS_Y2,
        MS_Y3
    } mul_step_t;

    typedef struct packed {
        logic               start;
        logic [TICK_W-1:0]  dividend;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [TICK_W-1:0]  quotient;
    } div_rsp_t;

endpackage

// File: hw/rtl/cubic_bezier_path_walker.sv
// ----------------------------------------------------------------------------
// cubic_bezier_path_walker
// walks a chain of cubic bezier segments, one position per advance request
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | content
//  s_       | in        | s_tvalid/s_tready  | command in tuser, tick and points
//  m_       | out       | m_tvalid/m_tready  | position, walking, status
//  cfg_     | in        | cfg_valid/cfg_ready| step_rate, end_wait
//
//  append, clear, a held advance and a start without segments go straight to the
//  response; start and an end-point advance first read the segment.
//  a computing advance passes the reciprocal tick divider, then the shared
//  multiplier, then the response; entering the next segment reads it first.
//  reset is synchronous; s_tready is low while a request is in work, and a
//  result waits in the output register, blocking only the end of the next request.
// ----------------------------------------------------------------------------
module cubic_bezier_path_walker
    import cbpw_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int TICK_DIVISOR = TICK_DIVISOR_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // tick_count, start_x, start_y, ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, end_x, end_y
    input  logic [127:0]  s_tdata,
    // command
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // pos_x, pos_y, walking, status, zero fill
    output logic [47:0]   m_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data
);

    localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNW-1:0] SEG_MAX = CNW'(MAX_SEGMENTS);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    cmd_t              cmd_in;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [TICK_W-1:0] tick_in;
    logic [RATE_W-1:0] step_rate_reg;
    logic [WAIT_W-1:0] end_wait_reg;
    logic [CNW-1:0]    total_reg, total_next;
    logic [CNW-1:0]    now_reg, now_next;
    logic [CNW-1:0]    now_inc;
    logic              done_reg, done_next;
    logic [T_W-1:0]    param_reg, param_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [TICK_W-1:0] start_tick_reg, start_tick_next;
    logic signed [CW-1:0] coef_reg [6];
    logic signed [CW-1:0] coef_next [6];
    logic [T2_W-1:0]   t2_reg, t2_next;
    logic [T3_W-1:0]   t3_reg, t3_next;
    logic signed [AW-1:0] accx_reg, accx_next;
    logic signed [AW-1:0] accy_reg, accy_next;
    logic signed [POS_W-1:0] held_x_reg, held_x_next;
    logic signed [POS_W-1:0] held_y_reg, held_y_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    mul_step_t         step_reg, step_next;
    logic signed [POS_W-1:0] out_px_reg, out_px_next;
    logic signed [POS_W-1:0] out_py_reg, out_py_next;
    logic              out_walk_reg, out_walk_next;
    logic              out_stat_reg, out_stat_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [47:0]       m_tdata_reg, m_tdata_next;

    logic              s_accept;
    logic              mem_we;
    logic              mem_re;
    logic [IW-1:0]     mem_raddr;
    logic [SEG_W-1:0]  mem_rdata;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic signed [CW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [COORD_BITS-1:0] pt [8];
    logic signed [CW-1:0] dx0, dy0, dx1, dy1, dxe, dye;
    logic signed [CW-1:0] c0x, c0y, d1x, d1y;
    logic              rate_big;
    logic [T_W-1:0]    t_val;
    logic              out_free;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cmd_in    = cmd_t'(s_tuser);
    assign tick_in   = s_tdata[TICK_W-1:0];
    assign now_inc   = now_reg + 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_rate_reg <= RATE_W'(1);
            end_wait_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_STEP_RATE: step_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_END_WAIT:  end_wait_reg  <= cfg_data[WAIT_W-1:0];
                default:       step_rate_reg <= step_rate_reg;
            endcase
        end
    end

    assign mem_we = s_accept && (cmd_in == CMD_APPEND) && (total_reg < SEG_MAX);

    cbpw_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .IW    (IW)
    ) u_seg_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (total_reg[IW-1:0]),
        .wdata (s_tdata[TICK_W +: SEG_W]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cbpw_tick_div #(
        .DIVISOR (TICK_DIVISOR)
    ) u_tick_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            pt[i] = mem_rdata[i*COORD_BITS +: COORD_BITS];
        end
        dx0 = CW'(pt[PT_C0X]) - CW'(pt[PT_SX]);
        dy0 = CW'(pt[PT_C0Y]) - CW'(pt[PT_SY]);
        dx1 = CW'(pt[PT_C1X]) - CW'(pt[PT_C0X]);
        dy1 = CW'(pt[PT_C1Y]) - CW'(pt[PT_C0Y]);
        dxe = CW'(pt[PT_EX]) - CW'(pt[PT_SX]);
        dye = CW'(pt[PT_EY]) - CW'(pt[PT_SY]);
        c0x = (dx0 <<< 1) + dx0;
        c0y = (dy0 <<< 1) + dy0;
        d1x = (dx1 <<< 1) + dx1;
        d1y = (dy1 <<< 1) + dy1;
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            MS_RATE:  begin
                mul_a = CW'(step_rate_reg);
                mul_b = BW'(div_rsp.quotient[T_W-1:0]);
            end
            MS_TSQ:   begin mul_a = CW'(param_reg); mul_b = BW'(param_reg); end
            MS_TCUBE: begin mul_a = CW'(t2_reg);    mul_b = BW'(param_reg); end
            MS_X1:    begin mul_a = coef_reg[0];    mul_b = BW'(param_reg); end
            MS_X2:    begin mul_a = coef_reg[1];    mul_b = BW'(t2_reg);    end
            MS_X3:    begin mul_a = coef_reg[2];    mul_b = BW'(t3_reg);    end
            MS_Y1:    begin mul_a = coef_reg[3];    mul_b = BW'(param_reg); end
            MS_Y2:    begin mul_a = coef_reg[4];    mul_b = BW'(t2_reg);    end
            MS_Y3:    begin mul_a = coef_reg[5];    mul_b = BW'(t3_reg);    end
            default:  begin mul_a = '0;             mul_b = '0;             end
        endcase
    end

    always_comb begin
        rate_big = (div_rsp.quotient[TICK_W-1:T_W] != '0) ? (step_rate_reg != '0)
                                                           : (prod_reg[PW-1:T_W] != '0);
        t_val    = rate_big ? T_MAX : prod_reg[T_W-1:0];
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        tick_next       = tick_reg;
        total_next      = total_reg;
        now_next        = now_reg;
        done_next       = done_reg;
        param_next      = param_reg;
        wait_next       = wait_reg;
        start_tick_next = start_tick_reg;
        for (int i = 0; i < 6; i++) begin
            coef_next[i] = coef_reg[i];
        end
        t2_next         = t2_reg;
        t3_next         = t3_reg;
        accx_next       = accx_reg;
        accy_next       = accy_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        prod_next       = prod_reg;
        step_next       = step_reg;
        out_px_next     = out_px_reg;
        out_py_next     = out_py_reg;
        out_walk_next   = out_walk_reg;
        out_stat_next   = out_stat_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        div_req.start    = 1'b0;
        div_req.dividend = ((state_reg == ST_IDLE) ? tick_in : tick_reg) - start_tick_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next      = cmd_in;
                    tick_next     = tick_in;
                    out_px_next   = '0;
                    out_py_next   = '0;
                    out_stat_next = 1'b0;
                    out_walk_next = !done_reg;
                    state_next    = ST_RESP;
                    unique case (cmd_in)
                        CMD_APPEND: begin
                            if (total_reg < SEG_MAX) begin
                                total_next = total_reg + 1'b1;
                            end else begin
                                out_stat_next = 1'b1;
                            end
                        end
                        CMD_START: begin
                            now_next        = '0;
                            done_next       = 1'b0;
                            start_tick_next = tick_in;
                            out_walk_next   = 1'b1;
                            if (total_reg != '0) begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                state_next = ST_LOAD;
                            end
                        end
                        CMD_CLEAR: begin
                            total_next    = '0;
                            now_next      = '0;
                            done_next     = 1'b1;
                            out_walk_next = 1'b0;
                        end
                        CMD_ADVANCE: begin
                            out_walk_next = 1'b1;
                            if (done_reg || now_reg >= total_reg ||
                                (param_reg > T_LIMIT && wait_reg == '0 &&
                                 now_inc >= total_reg)) begin
                                if (!(done_reg || now_reg >= total_reg)) begin
                                    now_next = now_inc;
                                end
                                done_next     = 1'b1;
                                out_walk_next = 1'b0;
                                if (total_reg != '0) begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = IW'(total_reg - 1'b1);
                                    state_next = ST_ENDPT;
                                end
                            end else if (param_reg <= T_LIMIT) begin
                                mem_re        = 1'b1;
                                mem_raddr     = now_reg[IW-1:0];
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end else if (wait_reg != '0) begin
                                wait_next   = wait_reg - 1'b1;
                                out_px_next = held_x_reg;
                                out_py_next = held_y_reg;
                            end else begin
                                now_next        = now_inc;
                                start_tick_next = tick_in;
                                mem_re          = 1'b1;
                                mem_raddr       = now_inc[IW-1:0];
                                state_next      = ST_LOAD;
                            end
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_LOAD: begin
                coef_next[0] = c0x;
                coef_next[1] = d1x - c0x;
                coef_next[2] = dxe - d1x;
                coef_next[3] = c0y;
                coef_next[4] = d1y - c0y;
                coef_next[5] = dye - d1y;
                param_next   = '0;
                wait_next    = end_wait_reg;
                if (cmd_reg == CMD_START) begin
                    state_next = ST_RESP;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    step_next  = MS_RATE;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PW'(mul_a * mul_b);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_MUL;
                step_next  = mul_step_t'(step_reg + 1'b1);
                case (step_reg) inside
                    MS_RATE:  param_next = t_val;
                    MS_TSQ:   t2_next = prod_reg[FRAC_BITS +: T2_W];
                    MS_TCUBE: t3_next = prod_reg[FRAC_BITS +: T3_W];
                    MS_X1:    accx_next = (AW'(pt[PT_SX]) <<< FRAC_BITS) + AW'(prod_reg);
                    MS_X2, MS_X3: accx_next = accx_reg + AW'(prod_reg);
                    MS_Y1:    accy_next = (AW'(pt[PT_SY]) <<< FRAC_BITS) + AW'(prod_reg);
                    MS_Y2:    accy_next = accy_reg + AW'(prod_reg);
                    MS_Y3: begin
                        accy_next   = accy_reg + AW'(prod_reg);
                        held_x_next = accx_reg[FRAC_BITS +: POS_W];
                        held_y_next = accy_next[FRAC_BITS +: POS_W];
                        out_px_next = held_x_next;
                        out_py_next = held_y_next;
                        state_next  = ST_RESP;
                    end
                    default: state_next = ST_RESP;
                endcase
            end
            ST_ENDPT: begin
                out_px_next = POS_W'(pt[PT_EX]);
                out_py_next = POS_W'(pt[PT_EY]);
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, out_stat_reg, out_walk_reg, out_py_reg, out_px_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            total_reg      <= '0;
            now_reg        <= '0;
            done_reg       <= 1'b1;
            param_reg      <= '0;
            wait_reg       <= '0;
            start_tick_reg <= '0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            step_reg       <= MS_RATE;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                coef_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            now_reg        <= now_next;
            done_reg       <= done_next;
            param_reg      <= param_next;
            wait_reg       <= wait_next;
            start_tick_reg <= start_tick_next;
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            step_reg       <= step_next;
            m_tvalid_reg   <= m_tvalid_next;
            for (int i = 0; i < 6; i++) begin
                coef_reg[i] <= coef_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        tick_reg     <= tick_next;
        t2_reg       <= t2_next;
        t3_reg       <= t3_next;
        accx_reg     <= accx_next;
        accy_reg     <= accy_next;
        prod_reg     <= prod_next;
        out_px_reg   <= out_px_next;
        out_py_reg   <= out_py_next;
        out_walk_reg <= out_walk_next;
        out_stat_reg <= out_stat_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= SEG_MAX)
        else $error("segment count above capacity");

    a_now_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        now_reg <= total_reg)
        else $error("segment index out of range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg != ST_IDLE)
        else $error("request accepted without work");

    a_reject_no_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[2*POS_W+1] |-> m_tdata_reg[2*POS_W-1:0] == '0)
        else $error("rejected append carries a position");

    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its state");
`endif

endmodule

// File: hw/rtl/cbpw_seg_mem.sv
// ----------------------------------------------------------------------------
// cbpw_seg_mem
// segment point store, one write port and one registered read port
// ----------------------------------------------------------------------------
module cbpw_seg_mem
    import cbpw_pkg::*;
#(
    parameter int DEPTH = MAX_SEGMENTS_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IW-1:0]    waddr,
    input  logic [SEG_W-1:0] wdata,
    input  logic             re,
    input  logic [IW-1:0]    raddr,
    output logic [SEG_W-1:0] rdata
);

    logic [SEG_W-1:0] mem [DEPTH];
    logic [SEG_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cbpw_tick_div.sv
// ----------------------------------------------------------------------------
// cbpw_tick_div
// division of the elapsed tick count by a constant, by reciprocal
// multiplication in two half-width passes
// ----------------------------------------------------------------------------
module cbpw_tick_div
    import cbpw_pkg::*;
#(
    parameter int DIVISOR = TICK_DIVISOR_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int SH    = $clog2(DIVISOR);
    localparam int MW    = TICK_W + 1;
    localparam int HW    = TICK_W / 2;
    localparam int PARTW = HW + MW;
    localparam int ACCW  = TICK_W + MW;
    localparam logic [63:0] ONE_SH = 64'd1 << (TICK_W + SH);
    localparam logic [MW-1:0] RECIP =
        MW'((ONE_SH + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [TICK_W-1:0] num_reg, num_next;
    logic [ACCW-1:0]   acc_reg, acc_next;
    logic              phase_reg, phase_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [HW-1:0]     half;
    logic [PARTW-1:0]  part;

    always_comb begin
        half       = phase_reg ? num_reg[TICK_W-1:HW] : num_reg[HW-1:0];
        part       = PARTW'(half) * PARTW'(RECIP);
        num_next   = num_reg;
        acc_next   = acc_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            num_next   = req.dividend;
            acc_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                acc_next   = ACCW'(part);
                phase_next = 1'b1;
            end else begin
                acc_next  = acc_reg + {part, {HW{1'b0}}};
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        acc_reg <= acc_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = TICK_W'(acc_reg >> (TICK_W + SH));

endmodule
